[rtl/rcdph_pkg.sv]
package rcdph_pkg;

    // Fixed geometry and register map
    localparam int MAX_FRAME = 16;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_PROTOCOL_OLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TX_ID        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BIND_COUNT   = 2'd2;

    localparam logic [15:0] BIND_COUNT_RESET = 16'd345;
    localparam logic [6:0]  FIRST_CHANNEL    = 7'd8;

    // Payload types
    typedef struct packed {
        logic [7:0] throttle;
        logic [7:0] rudder;
        logic [7:0] elevator;
        logic [7:0] aileron;
        logic       flip;
        logic       video;
        logic       picture;
        logic       headless;
    } in_t;

    typedef struct packed {
        logic [6:0] rf_channel;
        logic [3:0] byte_index;
        logic [7:0] payload_byte;
        logic       wait_long;
        logic       last;
    } out_t;

    // Link phase, controller state, frame kind
    typedef enum logic [1:0] {
        PH_INIT,
        PH_BIND_FIRST,
        PH_BIND,
        PH_DATA
    } phase_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHAN,
        S_EMIT,
        S_LOAD
    } state_t;

    typedef enum logic [1:0] {
        FK_FIRST,
        FK_BIND,
        FK_DATA
    } fk_t;

    // Controller to datapath commands
    typedef struct packed {
        logic cap;
        fk_t  kind;
        logic bind_load;
        logic bind_dec;
        logic chan_load;
        logic step;
        logic hop;
        logic load_start;
        logic load_data;
        logic load_wr;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic bind_zero;
        logic last_byte;
        logic load_last;
    } stat_t;

    // Constant tables (last entry of 15-entry lists is padding, never read)
    localparam logic [7:0] FIRST_PAYLOAD [16] = '{
        8'hf9, 8'h96, 8'h82, 8'h1b, 8'h20, 8'h08, 8'h08, 8'hf2,
        8'h7d, 8'hef, 8'hff, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };
    localparam logic [7:0] BIND_HOPS_NEW [4] = '{8'h4b, 8'h30, 8'h40, 8'h20};
    localparam logic [7:0] BIND_HOPS_OLD [16] = '{
        8'h27, 8'h1b, 8'h39, 8'h28, 8'h24, 8'h22, 8'h2e, 8'h36,
        8'h19, 8'h21, 8'h29, 8'h14, 8'h1e, 8'h12, 8'h2d, 8'h18
    };
    localparam logic [7:0] DATA_HOPS_OLD [16] = '{
        8'h1d, 8'h2f, 8'h26, 8'h3d, 8'h15, 8'h2b, 8'h25, 8'h24,
        8'h27, 8'h2c, 8'h1c, 8'h3e, 8'h39, 8'h2d, 8'h22, 8'h00
    };
    localparam logic [7:0] BASE_LOW  [4] = '{8'h0a, 8'h1a, 8'h2a, 8'h3a};
    localparam logic [7:0] BASE_MID  [4] = '{8'h2a, 8'h0a, 8'h42, 8'h22};
    localparam logic [7:0] BASE_HIGH [4] = '{8'h1a, 8'h3a, 8'h12, 8'h32};
    localparam logic [7:0] HOPS_ID_1E [4] = '{8'h21, 8'h41, 8'h18, 8'h38};
    localparam logic [7:0] HOPS_ID_1F [4] = '{8'h21, 8'h41, 8'h19, 8'h39};

    // Stick trim byte for the old frame
    function automatic logic [7:0] trim_old(input logic [7:0] x);
        logic [7:0] v;
        v = x[7] ? (8'hff - x) : (8'h80 + x);
        return {2'b00, v[7:2]} + 8'h20;
    endfunction

    // Number of hop table entries for a load
    function automatic logic [4:0] hop_count(input logic old, input logic data);
        logic [4:0] n;
        if (data)
            n = old ? 5'd15 : 5'd4;
        else
            n = old ? 5'd16 : 5'd4;
        return n;
    endfunction

    // Hop table entry i for a bind or data load
    function automatic logic [6:0] hop_src(input logic old, input logic data,
                                           input logic [3:0] i, input logic [4:0] a);
        logic [7:0] t;
        logic [4:0] aa;
        logic [1:0] j;
        j  = i[1:0];
        aa = (a == 5'd6) ? 5'd7 : a;
        if (!data)
            t = old ? BIND_HOPS_OLD[i] : BIND_HOPS_NEW[j];
        else if (old)
            t = DATA_HOPS_OLD[i];
        else if (a < 5'h10)
            t = BASE_LOW[j] + {3'b000, aa};
        else if (a < 5'h18)
        begin
            t = BASE_MID[j] + {5'b00000, a[2:0]};
            if (a == 5'h16 && !j[1])
                t = t + 8'd1;
        end
        else if (a < 5'h1e)
            t = BASE_HIGH[j] + {5'b00000, a[2:0]};
        else if (a == 5'h1e)
            t = HOPS_ID_1E[j];
        else
            t = HOPS_ID_1F[j];
        return t[6:0];
    endfunction

    // Index of the final byte of a payload
    function automatic logic [3:0] last_index(input fk_t fk, input logic old);
        logic [3:0] n;
        if (fk == FK_FIRST)
            n = 4'd14;
        else
            n = old ? 4'd15 : 4'd9;
        return n;
    endfunction

    // Payload byte k; acc holds the running checksum of bytes before k
    function automatic logic [7:0] frame_byte(input fk_t fk, input logic old,
                                              input logic [3:0] k, input in_t d,
                                              input logic [31:0] id,
                                              input logic [7:0] acc);
        logic [7:0] b;
        b = 8'h00;
        case (fk)
            FK_FIRST: b = FIRST_PAYLOAD[k];
            FK_BIND:
            begin
                if (old)
                begin
                    case (k)
                        4'd7:    b = 8'hae;
                        4'd8:    b = 8'ha9;
                        4'd14:   b = 8'hc0;
                        4'd15:   b = 8'h17;
                        default: b = 8'h00;
                    endcase
                end
                else
                begin
                    case (k)
                        4'd0:    b = 8'ha2;
                        4'd1:    b = id[31:24];
                        4'd2:    b = id[23:16];
                        4'd3:    b = id[15:8];
                        4'd4:    b = id[7:0];
                        4'd5, 4'd6, 4'd7: b = 8'haa;
                        4'd9:    b = acc + 8'h55;
                        default: b = 8'h00;
                    endcase
                end
            end
            FK_DATA:
            begin
                if (old)
                begin
                    case (k)
                        4'd0:    b = d.throttle;
                        4'd1:    b = d.rudder;
                        4'd2:    b = d.elevator ^ 8'h80;
                        4'd3:    b = d.aileron;
                        4'd4:    b = trim_old(d.rudder ^ 8'h80);
                        4'd5:    b = trim_old(d.elevator);
                        4'd6:    b = trim_old(d.aileron ^ 8'h80);
                        4'd7:    b = 8'hae;
                        4'd8:    b = 8'ha9;
                        4'd14:   b = {3'b000, d.video, d.picture, 1'b1, 1'b0, d.flip};
                        4'd15:   b = acc;
                        default: b = 8'h00;
                    endcase
                end
                else
                begin
                    case (k)
                        4'd0:    b = d.throttle;
                        4'd1:    b = d.elevator;
                        4'd2:    b = d.rudder;
                        4'd3:    b = d.aileron;
                        4'd4:    b = {d.video, d.picture, 6'b000000};
                        4'd5:    b = {2'b11, d.elevator[7:2]};
                        4'd6:    b = {1'b0, d.flip, d.rudder[7:2]};
                        4'd7:    b = {d.headless, 1'b0, d.aileron[7:2]};
                        4'd9:    b = acc + 8'h55;
                        default: b = 8'h00;
                    endcase
                end
            end
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

[rtl/rcdph_ctrl.sv]
module rcdph_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  rcdph_pkg::stat_t   stat,
    output rcdph_pkg::cmd_t    cmd
);

    rcdph_pkg::state_t state_reg, state_next;
    rcdph_pkg::phase_t phase_reg, phase_next;

    // State and phase registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rcdph_pkg::S_IDLE;
            phase_reg <= rcdph_pkg::PH_INIT;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    // Sequencing of one tick: capture, channel read, byte emission, table load
    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        cmd        = '0;
        cmd.kind   = rcdph_pkg::FK_DATA;

        case (state_reg)
            rcdph_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    case (phase_reg)
                        rcdph_pkg::PH_INIT:
                        begin
                            cmd.cap    = 1'b1;
                            cmd.kind   = rcdph_pkg::FK_FIRST;
                            state_next = rcdph_pkg::S_EMIT;
                        end
                        rcdph_pkg::PH_BIND_FIRST:
                        begin
                            cmd.cap       = 1'b1;
                            cmd.kind      = rcdph_pkg::FK_BIND;
                            cmd.bind_load = 1'b1;
                            phase_next    = rcdph_pkg::PH_BIND;
                            state_next    = rcdph_pkg::S_CHAN;
                        end
                        rcdph_pkg::PH_BIND:
                        begin
                            if (stat.bind_zero)
                            begin
                                // bind over: silent tick, load data hops
                                cmd.load_start = 1'b1;
                                cmd.load_data  = 1'b1;
                                phase_next     = rcdph_pkg::PH_DATA;
                                state_next     = rcdph_pkg::S_LOAD;
                            end
                            else
                            begin
                                cmd.cap      = 1'b1;
                                cmd.kind     = rcdph_pkg::FK_BIND;
                                cmd.bind_dec = 1'b1;
                                state_next   = rcdph_pkg::S_CHAN;
                            end
                        end
                        default:
                        begin
                            cmd.cap    = 1'b1;
                            cmd.kind   = rcdph_pkg::FK_DATA;
                            state_next = rcdph_pkg::S_CHAN;
                        end
                    endcase
                end
            end
            rcdph_pkg::S_CHAN:
            begin
                cmd.chan_load = 1'b1;
                state_next    = rcdph_pkg::S_EMIT;
            end
            rcdph_pkg::S_EMIT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    cmd.step = 1'b1;
                    if (stat.last_byte)
                    begin
                        if (phase_reg == rcdph_pkg::PH_INIT)
                        begin
                            // first payload done: load bind hops, no hop step
                            cmd.load_start = 1'b1;
                            phase_next     = rcdph_pkg::PH_BIND_FIRST;
                            state_next     = rcdph_pkg::S_LOAD;
                        end
                        else
                        begin
                            cmd.hop    = 1'b1;
                            state_next = rcdph_pkg::S_IDLE;
                        end
                    end
                end
            end
            rcdph_pkg::S_LOAD:
            begin
                cmd.load_wr = 1'b1;
                if (stat.load_last)
                    state_next = rcdph_pkg::S_IDLE;
            end
            default:
            begin
                state_next = rcdph_pkg::S_IDLE;
            end
        endcase
    end

endmodule

[rtl/rcdph_dp.sv]
module rcdph_dp
#(
    parameter int MAX_HOPS = 16
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [rcdph_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rcdph_pkg::CFG_W-1:0]         cfg_data,
    input  rcdph_pkg::in_t                      in_data,
    input  rcdph_pkg::cmd_t                     cmd,
    output rcdph_pkg::stat_t                    stat,
    output rcdph_pkg::out_t                     out_data
);

    localparam int HIDX_W = $clog2(MAX_HOPS);
    localparam int HLEN_W = $clog2(MAX_HOPS + 1);

    // Configuration
    logic        protocol_old_reg;
    logic [31:0] tx_id_reg;
    logic [15:0] bind_count_reg;

    // Control state
    logic [15:0]       bind_left_reg;
    logic [HIDX_W-1:0] hop_index_reg;
    logic [HLEN_W-1:0] hop_length_reg;
    logic              parity_reg;
    logic [3:0]        cnt_reg;
    rcdph_pkg::fk_t    kind_reg;
    logic              load_data_reg;

    // Payload state
    rcdph_pkg::in_t    in_reg;
    logic [7:0]        acc_reg;
    logic [6:0]        chan_reg;
    logic [6:0]        hop_mem [MAX_HOPS];

    logic [HLEN_W-1:0] hop_nx;
    logic [HLEN_W-1:0] hop_last;
    logic [7:0]        byte_now;
    logic [3:0]        last_idx;

    // Config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            protocol_old_reg <= 1'b0;
            tx_id_reg        <= '0;
            bind_count_reg   <= rcdph_pkg::BIND_COUNT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rcdph_pkg::CFG_PROTOCOL_OLD: protocol_old_reg <= cfg_data[0];
                rcdph_pkg::CFG_TX_ID:        tx_id_reg        <= cfg_data;
                rcdph_pkg::CFG_BIND_COUNT:   bind_count_reg   <= cfg_data[15:0];
                default:                     ;
            endcase
        end
    end

    // Current byte and hop arithmetic
    always_comb
    begin
        last_idx = rcdph_pkg::last_index(kind_reg, protocol_old_reg);
        byte_now = rcdph_pkg::frame_byte(kind_reg, protocol_old_reg, cnt_reg,
                                         in_reg, tx_id_reg, acc_reg);
        hop_nx   = HLEN_W'(hop_index_reg) + HLEN_W'(1);
        hop_last = hop_length_reg - HLEN_W'(1);
    end

    // Control registers: counters, hop position, bind countdown
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bind_left_reg  <= '0;
            hop_index_reg  <= '0;
            hop_length_reg <= '0;
            parity_reg     <= 1'b0;
            cnt_reg        <= '0;
            kind_reg       <= rcdph_pkg::FK_FIRST;
            load_data_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.bind_load)
                bind_left_reg <= bind_count_reg;
            else if (cmd.bind_dec)
                bind_left_reg <= bind_left_reg - 16'd1;

            if (cmd.cap)
                kind_reg <= cmd.kind;

            if (cmd.cap || cmd.load_start)
                cnt_reg <= '0;
            else if (cmd.step || cmd.load_wr)
                cnt_reg <= cnt_reg + 4'd1;

            if (cmd.load_start)
            begin
                load_data_reg  <= cmd.load_data;
                hop_length_reg <= HLEN_W'(rcdph_pkg::hop_count(protocol_old_reg,
                                                               cmd.load_data));
                hop_index_reg  <= '0;
                parity_reg     <= 1'b0;
            end
            else if (cmd.hop)
            begin
                // move on after every second payload, wrap at table length
                if (parity_reg)
                    hop_index_reg <= (hop_nx >= hop_length_reg) ? '0 : hop_nx[HIDX_W-1:0];
                parity_reg <= ~parity_reg;
            end
        end
    end

    // Input capture, checksum accumulation, channel read
    always_ff @(posedge clk)
    begin
        if (cmd.cap)
        begin
            in_reg  <= in_data;
            acc_reg <= '0;
        end
        else if (cmd.step)
            acc_reg <= protocol_old_reg ? (acc_reg + byte_now) : (acc_reg ^ byte_now);

        if (cmd.chan_load)
            chan_reg <= (HLEN_W'(hop_index_reg) < hop_length_reg) ?
                        hop_mem[hop_index_reg] : 7'd0;
    end

    // Hop table, one entry per cycle during a load sweep
    always_ff @(posedge clk)
    begin
        if (cmd.load_wr)
            hop_mem[HIDX_W'(cnt_reg)] <= rcdph_pkg::hop_src(protocol_old_reg, load_data_reg,
                                                            cnt_reg, tx_id_reg[4:0]);
    end

    // Status and result
    always_comb
    begin
        stat.bind_zero = (bind_left_reg == 16'd0);
        stat.last_byte = (cnt_reg == last_idx);
        stat.load_last = (HLEN_W'(cnt_reg) == hop_last);

        out_data.rf_channel   = (kind_reg == rcdph_pkg::FK_FIRST) ?
                                rcdph_pkg::FIRST_CHANNEL : chan_reg;
        out_data.byte_index   = cnt_reg;
        out_data.payload_byte = byte_now;
        out_data.wait_long    = (kind_reg == rcdph_pkg::FK_FIRST);
        out_data.last         = (cnt_reg == last_idx);
    end

endmodule

[rtl/rc_drone_packet_framer_hopper.sv]
// Packet framer and channel hopper for a toy-drone RC transmit link. Each
// accepted request is one packet-slot tick carrying the stick bytes and flags;
// the block answers with the payload of that tick one byte per result, each
// tagged with RF channel, byte position, wait request and a last-byte mark.
// A tick that sends an N-byte payload (15 init, 16 old frame, 10 new frame)
// first captures the request and reads the hop table, then gives one byte
// per cycle from the byte sequencer while the sink does not stall. The init
// tick reads no hop table and then loads the bind hop table, 16 or 4 entries;
// the silent tick that ends bind loads the data hop table, 15 or 4 entries,
// one entry per cycle through its single write port. A new request is taken
// only once the previous tick has finished. Configuration is written through
// cfg_we/cfg_index/cfg_data and must be changed only while the block is
// idle.
module rc_drone_packet_framer_hopper
#(
    parameter int MAX_HOPS = 16
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  rcdph_pkg::in_t                      in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output rcdph_pkg::out_t                     out_data,
    input  logic                                cfg_we,
    input  logic [rcdph_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rcdph_pkg::CFG_W-1:0]         cfg_data
);

    rcdph_pkg::cmd_t  cmd;
    rcdph_pkg::stat_t stat;

    // Controller
    rcdph_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Datapath
    rcdph_dp #(
        .MAX_HOPS (MAX_HOPS)
    ) u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_data  (out_data)
    );

    // One tick at a time: no request taken while bytes are offered
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("request accepted while a payload is being sent");

    // Bytes of a payload come out in consecutive positions
    a_byte_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_data.last |=>
            out_valid && (out_data.byte_index == 4'($past(out_data.byte_index) + 4'd1)))
        else $error("payload byte position skipped");

    // Output goes quiet after the final byte of a payload
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && out_data.last |=> !out_valid)
        else $error("result offered straight after last byte");

    // Long wait only on the init payload, which always uses the init channel
    a_wait_chan: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.wait_long |-> out_data.rf_channel == rcdph_pkg::FIRST_CHANNEL)
        else $error("long wait outside the init payload");

endmodule

[tb/rc_drone_packet_framer_hopper_tb.sv]
`timescale 1ns / 1ps

module rc_drone_packet_framer_hopper_tb;

    import rcdph_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE       = 40;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AFTER   = 300;
    localparam int CHUNK        = 130;

    localparam logic [6:0] INIT_CHANNEL = 7'h08;

    // Link constants: start-up payload and hop tables
    localparam logic [7:0] FIRST_FRAME [15] = '{
        8'hf9, 8'h96, 8'h82, 8'h1b, 8'h20, 8'h08, 8'h08, 8'hf2,
        8'h7d, 8'hef, 8'hff, 8'h00, 8'h00, 8'h00, 8'h00
    };
    localparam logic [6:0] BIND_CH_NEW [4] = '{7'h4b, 7'h30, 7'h40, 7'h20};
    localparam logic [6:0] BIND_CH_OLD [16] = '{
        7'h27, 7'h1b, 7'h39, 7'h28, 7'h24, 7'h22, 7'h2e, 7'h36,
        7'h19, 7'h21, 7'h29, 7'h14, 7'h1e, 7'h12, 7'h2d, 7'h18
    };
    localparam logic [6:0] DATA_CH_OLD [15] = '{
        7'h1d, 7'h2f, 7'h26, 7'h3d, 7'h15, 7'h2b, 7'h25, 7'h24,
        7'h27, 7'h2c, 7'h1c, 7'h3e, 7'h39, 7'h2d, 7'h22
    };
    localparam logic [6:0] ID_CH_LOW  [4] = '{7'h0a, 7'h1a, 7'h2a, 7'h3a};
    localparam logic [6:0] ID_CH_MID  [4] = '{7'h2a, 7'h0a, 7'h42, 7'h22};
    localparam logic [6:0] ID_CH_HIGH [4] = '{7'h1a, 7'h3a, 7'h12, 7'h32};
    localparam logic [6:0] ID_CH_1E   [4] = '{7'h21, 7'h41, 7'h18, 7'h38};
    localparam logic [6:0] ID_CH_1F   [4] = '{7'h21, 7'h41, 7'h19, 7'h39};

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic   in_valid = 1'b0;
    logic   in_ready;
    in_t    in_data = '0;
    logic   out_valid;
    logic   out_ready = 1'b0;
    out_t   out_data;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_PROTOCOL_OLD;
    logic [CFG_W-1:0]     cfg_data = '0;

    // Register shadows
    logic        cfg_old = 1'b0;
    logic [31:0] cfg_id = 32'h0;
    logic [15:0] cfg_bind = 16'd345;

    // Link state as the block should hold it
    phase_t      link_phase = PH_INIT;
    logic [15:0] bind_left = 16'h0;
    int          hop_idx = 0;
    logic        hop_parity = 1'b0;
    int          hop_len = 0;
    logic [6:0]  hop_tab [16];
    logic [7:0]  frame_bytes [16];

    in_t  pending_ticks [$];
    out_t expected_bytes [$];
    out_t want_byte;

    int unsigned send_gap_pct = 16;
    int unsigned recv_stall_pct = 47;
    int unsigned bytes_seen = 0;
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;
    int unsigned errors = 0;
    int unsigned cycle_count = 0;

    rc_drone_packet_framer_hopper u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Old-frame trim byte from a stick byte
    function automatic logic [7:0] stick_trim(input logic [7:0] x);
        logic [7:0] v;
        if (x[7])
            v = 8'hff - x;
        else
            v = 8'h80 + x;
        return (v >> 2) + 8'h20;
    endfunction

    // Queue the first n bytes of frame_bytes as expected results
    task automatic queue_payload_bytes(input int n, input logic [6:0] chan, input logic wl);
        out_t o;
        int   k;
        for (k = 0; k < n; k++)
        begin
            o.rf_channel   = chan;
            o.byte_index   = k[3:0];
            o.payload_byte = frame_bytes[k];
            o.wait_long    = wl;
            o.last         = (k == n - 1);
            expected_bytes.push_back(o);
        end
    endtask

    // Reload the hop table (bind set or id-derived data set)
    task automatic load_hop_table(input bit data_set);
        int         k;
        logic [4:0] a;
        a = cfg_id[4:0];
        hop_idx    = 0;
        hop_parity = 1'b0;
        if (!data_set)
        begin
            hop_len = cfg_old ? 16 : 4;
            for (k = 0; k < hop_len; k++)
                hop_tab[k] = cfg_old ? BIND_CH_OLD[k] : BIND_CH_NEW[k % 4];
        end
        else if (cfg_old)
        begin
            hop_len = 15;
            for (k = 0; k < 15; k++)
                hop_tab[k] = DATA_CH_OLD[k];
        end
        else
        begin
            hop_len = 4;
            for (k = 0; k < 4; k++)
            begin
                if (a < 5'h10)
                    hop_tab[k] = ID_CH_LOW[k] + ((a == 5'd6) ? 7'd7 : {2'b00, a});
                else if (a < 5'h18)
                    hop_tab[k] = ID_CH_MID[k] + {4'b0000, a[2:0]}
                                 + ((a == 5'h16 && k < 2) ? 7'd1 : 7'd0);
                else if (a < 5'h1e)
                    hop_tab[k] = ID_CH_HIGH[k] + {4'b0000, a[2:0]};
                else if (a == 5'h1e)
                    hop_tab[k] = ID_CH_1E[k];
                else
                    hop_tab[k] = ID_CH_1F[k];
            end
        end
    endtask

    // Build a bind or data frame, queue it and step the hopper
    task automatic queue_frame(input bit bind_frame, input in_t d);
        int         k;
        int         n;
        logic [7:0] acc;
        for (k = 0; k < 16; k++)
            frame_bytes[k] = 8'h00;
        acc = 8'h00;
        if (cfg_old)
        begin
            frame_bytes[7] = 8'hae;
            frame_bytes[8] = 8'ha9;
            if (bind_frame)
            begin
                frame_bytes[14] = 8'hc0;
                frame_bytes[15] = 8'h17;
            end
            else
            begin
                frame_bytes[0]  = d.throttle;
                frame_bytes[1]  = d.rudder;
                frame_bytes[2]  = d.elevator ^ 8'h80;
                frame_bytes[3]  = d.aileron;
                frame_bytes[4]  = stick_trim(d.rudder ^ 8'h80);
                frame_bytes[5]  = stick_trim(d.elevator);
                frame_bytes[6]  = stick_trim(d.aileron ^ 8'h80);
                frame_bytes[14] = 8'h04 | (d.video ? 8'h10 : 8'h00)
                                  | (d.picture ? 8'h08 : 8'h00) | (d.flip ? 8'h01 : 8'h00);
                for (k = 0; k < 15; k++)
                    acc = acc + frame_bytes[k];
                frame_bytes[15] = acc;
            end
            n = 16;
        end
        else
        begin
            if (bind_frame)
            begin
                frame_bytes[0] = 8'ha2;
                frame_bytes[1] = cfg_id[31:24];
                frame_bytes[2] = cfg_id[23:16];
                frame_bytes[3] = cfg_id[15:8];
                frame_bytes[4] = cfg_id[7:0];
                frame_bytes[5] = 8'haa;
                frame_bytes[6] = 8'haa;
                frame_bytes[7] = 8'haa;
            end
            else
            begin
                frame_bytes[0] = d.throttle;
                frame_bytes[1] = d.elevator;
                frame_bytes[2] = d.rudder;
                frame_bytes[3] = d.aileron;
                frame_bytes[4] = (d.video ? 8'h80 : 8'h00) | (d.picture ? 8'h40 : 8'h00);
                frame_bytes[5] = (d.elevator >> 2) | 8'hc0;
                frame_bytes[6] = (d.rudder >> 2) | (d.flip ? 8'h40 : 8'h00);
                frame_bytes[7] = (d.aileron >> 2) | (d.headless ? 8'h80 : 8'h00);
            end
            for (k = 0; k < 9; k++)
                acc = acc ^ frame_bytes[k];
            frame_bytes[9] = acc + 8'h55;
            n = 10;
        end
        queue_payload_bytes(n, hop_tab[hop_idx], 1'b0);
        // channel moves on after every second payload
        if (hop_parity)
            hop_idx = (hop_idx + 1) % hop_len;
        hop_parity = !hop_parity;
    endtask

    // One packet-slot tick through the phase machine
    task automatic advance_link(input in_t d);
        int k;
        case (link_phase)
            PH_INIT:
            begin
                for (k = 0; k < 15; k++)
                    frame_bytes[k] = FIRST_FRAME[k];
                queue_payload_bytes(15, INIT_CHANNEL, 1'b1);
                load_hop_table(1'b0);
                link_phase = PH_BIND_FIRST;
            end
            PH_BIND_FIRST:
            begin
                bind_left  = cfg_bind;
                link_phase = PH_BIND;
                queue_frame(1'b1, d);
            end
            PH_BIND:
            begin
                // last bind tick is silent and switches to the data table
                if (bind_left == 16'h0)
                begin
                    load_hop_table(1'b1);
                    link_phase = PH_DATA;
                end
                else
                begin
                    queue_frame(1'b1, d);
                    bind_left = bind_left - 16'd1;
                end
            end
            default:
                queue_frame(1'b0, d);
        endcase
    endtask

    function automatic logic [7:0] stick_value();
        logic [7:0] v;
        case ($urandom_range(7))
            0:       v = 8'h00;
            1:       v = 8'hff;
            2:       v = 8'h80;
            3:       v = 8'h7f;
            default: v = 8'($urandom_range(255));
        endcase
        return v;
    endfunction

    function automatic in_t random_tick();
        in_t t;
        t.throttle = stick_value();
        t.rudder   = stick_value();
        t.elevator = stick_value();
        t.aileron  = stick_value();
        t.flip     = 1'($urandom_range(1));
        t.video    = 1'($urandom_range(1));
        t.picture  = 1'($urandom_range(1));
        t.headless = 1'($urandom_range(1));
        return t;
    endfunction

    // Register write; shadows follow at once since writes happen only when idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_PROTOCOL_OLD: cfg_old  = val[0];
            CFG_TX_ID:        cfg_id   = val;
            CFG_BIND_COUNT:   cfg_bind = val[15:0];
            default:          ;
        endcase
    endtask

    // Wait for all requests taken and all bytes back, then let the block settle
    task automatic drain();
        do
            @(negedge clk);
        while (pending_ticks.size() != 0 || in_valid || expected_bytes.size() != 0);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic push_random(input int count);
        int k;
        for (k = 0; k < count; k++)
            pending_ticks.push_back(random_tick());
    endtask

    // Stick extremes, centre values and each flag on its own
    // flags are {flip, video, picture, headless}
    task automatic push_directed();
        pending_ticks.push_back({8'h00, 8'h00, 8'h00, 8'h00, 4'b0000});
        pending_ticks.push_back({8'hff, 8'hff, 8'hff, 8'hff, 4'b1111});
        pending_ticks.push_back({8'h00, 8'h80, 8'h80, 8'h80, 4'b0000});
        pending_ticks.push_back({8'hff, 8'h7f, 8'h7f, 8'h7f, 4'b0000});
        pending_ticks.push_back({8'h80, 8'h81, 8'h81, 8'h81, 4'b0000});
        pending_ticks.push_back({8'h01, 8'hfe, 8'h01, 8'hfe, 4'b1000});
        pending_ticks.push_back({8'h7f, 8'h00, 8'hff, 8'h00, 4'b0100});
        pending_ticks.push_back({8'h55, 8'haa, 8'h55, 8'haa, 4'b0010});
        pending_ticks.push_back({8'haa, 8'h55, 8'haa, 8'h55, 4'b0001});
        pending_ticks.push_back({8'h80, 8'hff, 8'h00, 8'h80, 4'b0101});
    endtask

    // Request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && in_ready)
                advance_link(in_data);
            if (!in_valid || in_ready)
            begin
                if (pending_ticks.size() != 0 && $urandom_range(99) >= send_gap_pct)
                begin
                    in_valid <= 1'b1;
                    in_data  <= pending_ticks.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Result monitor and sink stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                bytes_seen++;
                if (expected_bytes.size() == 0)
                begin
                    $error("unexpected result byte %p", out_data);
                    errors++;
                end
                else
                begin
                    want_byte = expected_bytes.pop_front();
                    if (out_data.rf_channel !== want_byte.rf_channel)
                    begin
                        $error("rf_channel: expected %0h, got %0h",
                               want_byte.rf_channel, out_data.rf_channel);
                        errors++;
                    end
                    if (out_data.byte_index !== want_byte.byte_index)
                    begin
                        $error("byte_index: expected %0d, got %0d",
                               want_byte.byte_index, out_data.byte_index);
                        errors++;
                    end
                    if (out_data.payload_byte !== want_byte.payload_byte)
                    begin
                        $error("payload_byte: expected %0h, got %0h",
                               want_byte.payload_byte, out_data.payload_byte);
                        errors++;
                    end
                    if (out_data.wait_long !== want_byte.wait_long)
                    begin
                        $error("wait_long: expected %0b, got %0b",
                               want_byte.wait_long, out_data.wait_long);
                        errors++;
                    end
                    if (out_data.last !== want_byte.last)
                    begin
                        $error("last: expected %0b, got %0b", want_byte.last, out_data.last);
                        errors++;
                    end
                end
            end
            // one long hold-off so the block backs up into its request side
            if (hold_left != 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (bytes_seen >= HOLD_AFTER && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Stimulus sequence
    initial
    begin
        logic [31:0] id_pick;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // start-up settings; bias the id towards the odd hop-table cases
        id_pick = $urandom;
        if ($urandom_range(1))
        begin
            case ($urandom_range(3))
                0:       id_pick[4:0] = 5'h06;
                1:       id_pick[4:0] = 5'h16;
                2:       id_pick[4:0] = 5'h1e;
                default: id_pick[4:0] = 5'h1f;
            endcase
        end
        write_reg(CFG_PROTOCOL_OLD, $urandom_range(1));
        write_reg(CFG_TX_ID, id_pick);
        write_reg(CFG_BIND_COUNT, $urandom_range(0, 6));

        // init tick and first bind tick
        @(negedge clk);
        push_random(2);
        drain();

        // switch frame layout mid-bind: table stays, frames follow the register
        write_reg(CFG_PROTOCOL_OLD, {31'h0, !cfg_old});
        @(negedge clk);
        push_random(cfg_bind + 1);
        push_directed();
        drain();

        write_reg(CFG_PROTOCOL_OLD, {31'h0, !cfg_old});
        @(negedge clk);
        push_directed();
        push_random(CHUNK);
        drain();

        send_gap_pct   = 47;
        recv_stall_pct = 16;
        write_reg(CFG_PROTOCOL_OLD, {31'h0, !cfg_old});
        write_reg(CFG_TX_ID, 32'h0000_0000);
        write_reg(CFG_BIND_COUNT, 32'h0000_0000);
        @(negedge clk);
        push_random(CHUNK);
        drain();

        send_gap_pct   = 0;
        recv_stall_pct = 0;
        write_reg(CFG_PROTOCOL_OLD, {31'h0, !cfg_old});
        write_reg(CFG_TX_ID, 32'hffff_ffff);
        write_reg(CFG_BIND_COUNT, 32'h0000_ffff);
        @(negedge clk);
        push_random(CHUNK);
        drain();

        if (errors == 0 && expected_bytes.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
